>>> design/cfm_pkg.sv
// Shared types and constants of the contactor feedback monitor.
`timescale 1ns / 1ps

package cfm_pkg;

	// Widths fixed by the register map and the tick fields.
	localparam int unsigned TIMER_W  = 16;
	localparam int unsigned BITS_W   = 8;
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned MAX_CH   = 8;
	localparam int unsigned CFG_W    = 64;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT  = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0]   MASKS_RESET  = '0;
	localparam logic [TIMER_W-1:0] FILTER_RESET = 16'd500;
	localparam logic [TIMER_W-1:0] SETTLE_RESET = 16'd3000;

	// Per-tick control shared by the settle tracker and the channel checkers.
	typedef struct packed {
		logic step;      // a tick is processed in this cycle
		logic checking;  // settling is over for this tick
	} ctrl_t;

endpackage

>>> design/cfm_settle.sv
// Settling timer and run-state edge tracker.
`timescale 1ns / 1ps

module cfm_settle #(
	parameter int unsigned TICK_STEP = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          run_active,
	input  logic [cfm_pkg::TIMER_W-1:0]   settle_limit,
	output cfm_pkg::ctrl_t                ctrl
);

	logic [cfm_pkg::TIMER_W-1:0] settle_timer_q;
	logic                        previous_run_q;
	logic [cfm_pkg::TIMER_W-1:0] timer_eff;
	logic [cfm_pkg::TIMER_W:0]   timer_sum;
	logic                        checking;

	// A run state change restarts settling in the same tick.
	assign timer_eff = (run_active != previous_run_q) ? '0 : settle_timer_q;
	assign checking  = timer_eff > settle_limit;
	assign timer_sum = {1'b0, timer_eff} + (cfm_pkg::TIMER_W + 1)'(TICK_STEP);

	assign ctrl.step     = step;
	assign ctrl.checking = checking;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_timer_q <= '0;
			previous_run_q <= 1'b0;
		end else if (step) begin
			previous_run_q <= run_active;
			if (checking) begin
				settle_timer_q <= timer_eff;
			end else if (timer_sum[cfm_pkg::TIMER_W]) begin
				settle_timer_q <= '1;
			end else begin
				settle_timer_q <= timer_sum[cfm_pkg::TIMER_W-1:0];
			end
		end
	end

endmodule

>>> design/cfm_channel.sv
// Mismatch timer and fault decision for one contactor channel.
`timescale 1ns / 1ps

module cfm_channel #(
	parameter int unsigned TICK_STEP = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfm_pkg::ctrl_t                ctrl,
	input  logic [cfm_pkg::MASK_W-1:0]    mask,
	input  logic [cfm_pkg::BITS_W-1:0]    output_state,
	input  logic                          feedback,
	input  logic [cfm_pkg::TIMER_W-1:0]   filter_limit,
	output logic                          fault
);

	logic [cfm_pkg::TIMER_W-1:0] timer_q;
	logic [cfm_pkg::TIMER_W-1:0] timer_next;
	logic [cfm_pkg::TIMER_W:0]   timer_sum;
	logic                        enabled;
	logic                        expect_on;

	assign enabled   = mask != '0;
	assign expect_on = (mask & output_state) != '0;
	assign timer_sum = {1'b0, timer_q} + (cfm_pkg::TIMER_W + 1)'(TICK_STEP);

	always_comb begin
		timer_next = timer_q;
		fault      = 1'b0;
		if (!ctrl.checking) begin
			timer_next = '0;
		end else if (enabled) begin
			if (expect_on != feedback) begin
				if (timer_q < filter_limit) begin
					timer_next = timer_sum[cfm_pkg::TIMER_W] ? '1
						: timer_sum[cfm_pkg::TIMER_W-1:0];
				end
			end else begin
				timer_next = '0;
			end
			fault = timer_next >= filter_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (ctrl.step) begin
			timer_q <= timer_next;
		end
	end

endmodule

>>> design/contactor_feedback_monitor.sv
// Top level of the contactor feedback monitor: registers, handshakes and channel array.
// A tick request accepted into the input register moves on to the result register when
// the evaluation stage fires. Throughput: one request per cycle while results are taken,
// all channel checks in parallel in one stage.
// Reset (arst_n low) clears all timers, the run history, the sticky faults and both
// valid flags, and loads the configuration registers with their reset values.
`timescale 1ns / 1ps

module contactor_feedback_monitor #(
	parameter int unsigned CHANNELS  = 8,
	parameter int unsigned TICK_STEP = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Tick request channel.
	input  logic                            tick_valid,
	output logic                            tick_ready,
	input  logic [cfm_pkg::BITS_W-1:0]      output_state,
	input  logic [cfm_pkg::BITS_W-1:0]      feedback_bits,
	input  logic                            run_active,
	// Result channel.
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [cfm_pkg::BITS_W-1:0]      fault_now,
	output logic [cfm_pkg::BITS_W-1:0]      fault_latched,
	output logic                            checking,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfm_pkg::CFG_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [cfm_pkg::CFG_W-1:0]   channel_masks_q;
	logic [cfm_pkg::TIMER_W-1:0] filter_limit_q;
	logic [cfm_pkg::TIMER_W-1:0] settle_limit_q;

	// Input register: one tick request waiting to be evaluated.
	logic                        valid_s1;
	logic [cfm_pkg::BITS_W-1:0]  output_state_s1;
	logic [cfm_pkg::BITS_W-1:0]  feedback_bits_s1;
	logic                        run_active_s1;

	// Result register.
	logic                        valid_s2;
	logic [cfm_pkg::BITS_W-1:0]  fault_now_s2;
	logic [cfm_pkg::BITS_W-1:0]  fault_latched_s2;
	logic                        checking_s2;

	logic [cfm_pkg::BITS_W-1:0]  latched_faults_q;
	logic [cfm_pkg::BITS_W-1:0]  fault_vec;
	logic [cfm_pkg::BITS_W-1:0]  latched_next;
	cfm_pkg::ctrl_t              ctrl;
	logic                        advance;

	// The evaluation stage fires whenever a request sits in the input register and
	// the result register is empty or being drained in this same cycle. All state
	// (timers, run history, sticky faults) updates only on that cycle.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign tick_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_masks_q <= cfm_pkg::MASKS_RESET;
			filter_limit_q  <= cfm_pkg::FILTER_RESET;
			settle_limit_q  <= cfm_pkg::SETTLE_RESET;
		end else if (cfg_valid) begin
			// Writes to an index beyond the register list are dropped.
			unique case (cfg_index)
				cfm_pkg::REG_CHANNEL_MASKS: channel_masks_q <= cfg_data;
				cfm_pkg::REG_FILTER_LIMIT:
					filter_limit_q <= cfg_data[cfm_pkg::TIMER_W-1:0];
				cfm_pkg::REG_SETTLE_LIMIT:
					settle_limit_q <= cfg_data[cfm_pkg::TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			output_state_s1  <= output_state;
			feedback_bits_s1 <= feedback_bits;
			run_active_s1    <= run_active;
		end
	end

	// Settling timer decides whether this tick checks the channels.
	cfm_settle #(
		.TICK_STEP (TICK_STEP)
	) u_settle (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.run_active   (run_active_s1),
		.settle_limit (settle_limit_q),
		.ctrl         (ctrl)
	);

	// One checker per channel; slots at or above CHANNELS never fault.
	for (genvar n = 0; n < cfm_pkg::MAX_CH; n++) begin : g_ch
		if (n < CHANNELS) begin : g_on
			cfm_channel #(
				.TICK_STEP (TICK_STEP)
			) u_channel (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.mask         (channel_masks_q[n*cfm_pkg::MASK_W +: cfm_pkg::MASK_W]),
				.output_state (output_state_s1),
				.feedback     (feedback_bits_s1[n]),
				.filter_limit (filter_limit_q),
				.fault        (fault_vec[n])
			);
		end else begin : g_off
			assign fault_vec[n] = 1'b0;
		end
	end

	// Faults are only reported while checking, so the raw vector is already zero
	// in settling ticks.
	assign latched_next = latched_faults_q | fault_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_faults_q <= '0;
			valid_s2         <= 1'b0;
		end else begin
			if (advance) begin
				latched_faults_q <= latched_next;
				valid_s2         <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fault_now_s2     <= fault_vec;
			fault_latched_s2 <= latched_next;
			checking_s2      <= ctrl.checking;
		end
	end

	assign result_valid  = valid_s2;
	assign fault_now     = fault_now_s2;
	assign fault_latched = fault_latched_s2;
	assign checking      = checking_s2;

endmodule

>>> design/cfm_checker.sv
// Port-level checker for the contactor feedback monitor and its bind.
`timescale 1ns / 1ps

module cfm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            tick_valid,
	input logic                            tick_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [cfm_pkg::BITS_W-1:0]      fault_now,
	input logic [cfm_pkg::BITS_W-1:0]      fault_latched,
	input logic                            checking
);

	logic                       in_acc;
	logic                       out_acc;
	logic [1:0]                 pending_q;
	logic [cfm_pkg::BITS_W-1:0] last_latched_q;

	assign in_acc  = tick_valid && tick_ready;
	assign out_acc = result_valid && result_ready;

	// Requests accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_latched_q <= '0;
		end else if (out_acc) begin
			last_latched_q <= fault_latched;
		end
	end

	// A result is never delivered without an outstanding request.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 2'd0)
		else $error("result delivered with no request outstanding");

	// At most two requests are held inside the block.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests in flight");

	// Current faults are part of the sticky set and appear only while checking.
	a_now_in_latched: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((fault_now & ~fault_latched) == '0)
			&& (checking || fault_now == '0))
		else $error("fault_now inconsistent with fault_latched or checking");

	// Sticky faults never clear between delivered results.
	a_latched_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (fault_latched & last_latched_q) == last_latched_q)
		else $error("latched fault bit cleared");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(fault_now)
			&& $stable(fault_latched) && $stable(checking))
		else $error("stalled result changed");

endmodule

bind contactor_feedback_monitor cfm_checker u_cfm_checker (.*);

>>> sim/tb_contactor_feedback_monitor.sv
// Self-checking testbench of the contactor feedback monitor with a predicting scoreboard.
`timescale 1ns / 1ps

// Keeps a private copy of the monitor's registers and timers. Every accepted tick request
// advances that copy by one tick and queues the status the block must return for it.
class cfm_scoreboard #(int unsigned CHANNELS = 8, int unsigned TICK_STEP = 5);

	typedef struct packed {
		logic [cfm_pkg::BITS_W-1:0] now;
		logic [cfm_pkg::BITS_W-1:0] latched;
		logic                       checking;
	} tick_status_t;

	logic [cfm_pkg::CFG_W-1:0]   masks;
	logic [cfm_pkg::TIMER_W-1:0] filter_lim;
	logic [cfm_pkg::TIMER_W-1:0] settle_lim;
	logic [cfm_pkg::TIMER_W-1:0] mm_timer [cfm_pkg::MAX_CH];
	logic [cfm_pkg::TIMER_W-1:0] settle_tmr;
	logic                        prev_run;
	logic [cfm_pkg::BITS_W-1:0]  sticky;

	tick_status_t status_due[$];
	int errors;
	int compared;
	int checked_ticks;
	int fault_ticks;

	function new();
		masks      = cfm_pkg::MASKS_RESET;
		filter_lim = cfm_pkg::FILTER_RESET;
		settle_lim = cfm_pkg::SETTLE_RESET;
		foreach (mm_timer[n])
			mm_timer[n] = '0;
		settle_tmr    = '0;
		prev_run      = 1'b0;
		sticky        = '0;
		errors        = 0;
		compared      = 0;
		checked_ticks = 0;
		fault_ticks   = 0;
	endfunction

	// Timers stop at all ones instead of wrapping.
	function logic [cfm_pkg::TIMER_W-1:0] step_up(logic [cfm_pkg::TIMER_W-1:0] v);
		logic [cfm_pkg::TIMER_W:0] s;
		s = {1'b0, v} + (cfm_pkg::TIMER_W+1)'(TICK_STEP);
		return s[cfm_pkg::TIMER_W] ? '1 : s[cfm_pkg::TIMER_W-1:0];
	endfunction

	function void write_reg(logic [cfm_pkg::CFG_IDX_W-1:0] idx, logic [cfm_pkg::CFG_W-1:0] data);
		case (idx)
			cfm_pkg::REG_CHANNEL_MASKS: masks      = data;
			cfm_pkg::REG_FILTER_LIMIT:  filter_lim = data[cfm_pkg::TIMER_W-1:0];
			cfm_pkg::REG_SETTLE_LIMIT:  settle_lim = data[cfm_pkg::TIMER_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_tick(logic [cfm_pkg::BITS_W-1:0] outs, logic [cfm_pkg::BITS_W-1:0] fb,
			logic run);
		tick_status_t st;
		logic [cfm_pkg::MASK_W-1:0] mask;
		logic want;
		if (run != prev_run)
			settle_tmr = '0;
		prev_run    = run;
		st.now      = '0;
		st.checking = settle_tmr > settle_lim;
		if (st.checking) begin
			for (int n = 0; n < cfm_pkg::MAX_CH; n++) begin
				mask = masks[cfm_pkg::MASK_W*n +: cfm_pkg::MASK_W];
				if (n < CHANNELS && mask != '0) begin
					want = (mask & outs) != '0;
					if (want != fb[n]) begin
						if (mm_timer[n] < filter_lim)
							mm_timer[n] = step_up(mm_timer[n]);
					end else begin
						mm_timer[n] = '0;
					end
					if (mm_timer[n] >= filter_lim)
						st.now[n] = 1'b1;
				end
			end
			sticky = sticky | st.now;
			checked_ticks++;
			if (st.now != '0)
				fault_ticks++;
		end else begin
			settle_tmr = step_up(settle_tmr);
			foreach (mm_timer[n])
				mm_timer[n] = '0;
		end
		st.latched = sticky;
		status_due.push_back(st);
	endfunction

	function void check_result(logic [cfm_pkg::BITS_W-1:0] now, logic [cfm_pkg::BITS_W-1:0] latched,
			logic chk);
		tick_status_t st;
		if (status_due.size() == 0) begin
			errors++;
			$display("%0t: result with no tick pending: fault_now %h fault_latched %h checking %b",
				$time, now, latched, chk);
			return;
		end
		st = status_due.pop_front();
		compared++;
		if (now !== st.now) begin
			errors++;
			$display("%0t: fault_now expected %h actual %h", $time, st.now, now);
		end
		if (latched !== st.latched) begin
			errors++;
			$display("%0t: fault_latched expected %h actual %h", $time, st.latched, latched);
		end
		if (chk !== st.checking) begin
			errors++;
			$display("%0t: checking expected %b actual %b", $time, st.checking, chk);
		end
	endfunction

	function int pending();
		return status_due.size();
	endfunction

endclass

module tb_contactor_feedback_monitor;

	localparam int unsigned CHANNELS  = 8;
	localparam int unsigned TICK_STEP = 5;
	localparam int unsigned HALF_NS   = 4;
	// Far above the slowest legal run, which stays below about a millisecond.
	localparam longint unsigned TIMEOUT_NS = 10_000_000;
	// Index 3 has no register behind it; a write there must change nothing.
	localparam logic [cfm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_TICKS   = 80;
	// Length of each of the two phases that run with a limit at all ones.
	localparam int LIMIT_TICKS   = 90;
	localparam int LONG_HOLD     = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic tick_valid;
	logic tick_ready;
	logic [cfm_pkg::BITS_W-1:0] output_state;
	logic [cfm_pkg::BITS_W-1:0] feedback_bits;
	logic run_active;
	logic result_valid;
	logic result_ready;
	logic [cfm_pkg::BITS_W-1:0] fault_now;
	logic [cfm_pkg::BITS_W-1:0] fault_latched;
	logic checking;
	logic cfg_valid;
	logic cfg_ready;
	logic [cfm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cfm_pkg::CFG_W-1:0] cfg_data;

	cfm_scoreboard #(.CHANNELS(CHANNELS), .TICK_STEP(TICK_STEP)) sb;

	// Stimulus state. The masks are mirrored here so that the feedback generator can
	// produce mostly plausible contactor behavior for the current configuration.
	logic [cfm_pkg::CFG_W-1:0]  cur_masks;
	logic [cfm_pkg::BITS_W-1:0] stuck;
	logic cur_run;
	int   run_div;
	bit   quiet;
	int   ticks_sent;
	int   results_seen;
	int   writes_done;

	contactor_feedback_monitor #(
		.CHANNELS (CHANNELS),
		.TICK_STEP(TICK_STEP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.output_state (output_state),
		.feedback_bits(feedback_bits),
		.run_active   (run_active),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.fault_now    (fault_now),
		.fault_latched(fault_latched),
		.checking     (checking),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#(HALF_NS) clk = 1'b1;
		#(HALF_NS) clk = 1'b0;
	end

	// Idle length for either side: mostly none, sometimes short, rarely long.
	// Quiet phases run back to back so that the block also sees full-rate streams.
	function automatic int idle_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The feedback a healthy plant would return: a channel reads 1 when any of its
	// masked output bits is commanded.
	function automatic logic [cfm_pkg::BITS_W-1:0] healthy_feedback(
			logic [cfm_pkg::BITS_W-1:0] outs);
		logic [cfm_pkg::BITS_W-1:0] w;
		for (int n = 0; n < cfm_pkg::MAX_CH; n++)
			w[n] = (cur_masks[cfm_pkg::MASK_W*n +: cfm_pkg::MASK_W] & outs) != '0;
		return w;
	endfunction

	// Offers one tick request after an optional idle gap. Valid is only lowered when a
	// gap follows, so back-to-back requests keep valid high without a glitch. The
	// scoreboard learns of the request at the edge that accepts it.
	task automatic send_tick(input logic [cfm_pkg::BITS_W-1:0] outs,
			input logic [cfm_pkg::BITS_W-1:0] fb, input logic run);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_valid    <= 1'b1;
		output_state  <= outs;
		feedback_bits <= fb;
		run_active    <= run;
		do
			@(posedge clk);
		while (!tick_ready);
		sb.note_tick(outs, fb, run);
		ticks_sent++;
	endtask

	task automatic stop_ticks();
		@(negedge clk);
		tick_valid <= 1'b0;
	endtask

	// Register writes are issued only with the pipeline empty, so the scoreboard may
	// update its copy at the accepting edge.
	task automatic write_reg(input logic [cfm_pkg::CFG_IDX_W-1:0] idx,
			input logic [cfm_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
		if (idx == cfm_pkg::REG_CHANNEL_MASKS)
			cur_masks = data;
		writes_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		stop_ticks();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One tick of the random stream. Most ticks look like a working plant: the run flag
	// stays put long enough to get past settling, and the feedback follows the command
	// except on channels that are currently stuck. Some ticks carry pure noise.
	task automatic random_tick();
		logic [cfm_pkg::BITS_W-1:0] outs;
		logic [cfm_pkg::BITS_W-1:0] fb;
		int r;
		outs = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 24) == 0)
			stuck[$urandom_range(0, cfm_pkg::MAX_CH-1)] ^= 1'b1;
		if ($urandom_range(0, run_div-1) == 0)
			cur_run = ~cur_run;
		r = $urandom_range(0, 99);
		if (r < 5)
			fb = 8'($urandom_range(0, 255));
		else if (r < 12)
			fb = healthy_feedback(outs) ^ stuck ^ (8'h01 << $urandom_range(0, 7));
		else
			fb = healthy_feedback(outs) ^ stuck;
		send_tick(outs, fb, cur_run);
	endtask

	// Mask word with a mix of disabled channels, single-bit masks and wide masks.
	function automatic logic [cfm_pkg::CFG_W-1:0] random_masks();
		logic [cfm_pkg::CFG_W-1:0] m;
		int r;
		for (int n = 0; n < cfm_pkg::MAX_CH; n++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				m[cfm_pkg::MASK_W*n +: cfm_pkg::MASK_W] = '0;
			else if (r < 50)
				m[cfm_pkg::MASK_W*n +: cfm_pkg::MASK_W] = 8'h01 << $urandom_range(0, 7);
			else
				m[cfm_pkg::MASK_W*n +: cfm_pkg::MASK_W] = 8'($urandom_range(1, 255));
		end
		return m;
	endfunction

	// Limit write with junk in the bits above the 16-bit register.
	function automatic logic [cfm_pkg::CFG_W-1:0] limit_word(logic [cfm_pkg::TIMER_W-1:0] v);
		return {$urandom, 16'($urandom_range(0, 65535)), v};
	endfunction

	// Result side: every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_result(fault_now, fault_latched, checking);
			results_seen++;
		end
	end

	// Result readiness. Besides the random stalls, the receiver holds off twice for a
	// long stretch while the sender keeps offering, so the block fills and stalls its
	// tick input.
	initial begin
		int stall_left;
		int holds_done;
		stall_left   = 0;
		holds_done   = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done < 2 && results_seen >= 400 + 500 * holds_done) begin
				stall_left = LONG_HOLD;
				holds_done++;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				stall_left = idle_gap();
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d results still outstanding", $time, sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [cfm_pkg::CFG_W-1:0] dir_masks;
		logic [cfm_pkg::BITS_W-1:0] lim_outs;
		sb            = new();
		arst_n        = 1'b0;
		tick_valid    = 1'b0;
		output_state  = '0;
		feedback_bits = '0;
		run_active    = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = cfm_pkg::REG_CHANNEL_MASKS;
		cfg_data      = '0;
		cur_masks     = cfm_pkg::MASKS_RESET;
		stuck         = '0;
		cur_run       = 1'b0;
		run_div       = 60;
		quiet         = 1'b0;
		ticks_sent    = 0;
		results_seen  = 0;
		writes_done   = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: masks are zero and settling is long, so nothing is checked.
		// Field extremes and both run levels.
		send_tick(8'h00, 8'h00, 1'b0);
		send_tick(8'hFF, 8'hFF, 1'b1);
		send_tick(8'hFF, 8'h00, 1'b1);
		send_tick(8'h00, 8'hFF, 1'b0);
		send_tick(8'hAA, 8'h55, 1'b0);
		drain();

		// Zero filter limit: only the top channel is enabled, and it must fault on its
		// first checked tick even though the feedback agrees.
		write_reg(cfm_pkg::REG_CHANNEL_MASKS, 64'h8000_0000_0000_0000);
		write_reg(cfm_pkg::REG_FILTER_LIMIT, 64'd0);
		write_reg(cfm_pkg::REG_SETTLE_LIMIT, 64'd0);
		send_tick(8'h00, 8'h00, 1'b0);
		send_tick(8'h00, 8'h00, 1'b0);
		send_tick(8'hFF, 8'hFF, 1'b0);
		send_tick(8'h80, 8'h00, 1'b0);
		send_tick(8'h00, 8'h00, 1'b1);
		send_tick(8'h00, 8'h00, 1'b1);
		drain();

		// Disabled channels (zero mask bytes), a write to the unused index, and a short
		// filter so that two mismatching ticks raise a fault.
		dir_masks = 64'h80_00_C3_00_81_00_10_06;
		write_reg(cfm_pkg::REG_CHANNEL_MASKS, dir_masks);
		write_reg(cfm_pkg::REG_FILTER_LIMIT, 64'd10);
		write_reg(cfm_pkg::REG_SETTLE_LIMIT, 64'd5);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_tick(8'h00, 8'h00, 1'b0);
		send_tick(8'h00, 8'h04, 1'b0);
		send_tick(8'h06, 8'h00, 1'b0);
		send_tick(8'h06, 8'h00, 1'b0);
		send_tick(8'h06, 8'h21, 1'b0);
		send_tick(8'hFF, 8'hFF, 1'b0);
		send_tick(8'h00, 8'hFF, 1'b0);
		send_tick(8'h00, 8'hFF, 1'b0);
		send_tick(8'h00, 8'h00, 1'b1);
		drain();

		// Random phases, each with its own configuration; the early ones pin the limits
		// and masks to their extremes.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 6)
				write_reg(cfm_pkg::REG_CHANNEL_MASKS, '1);
			else if (p == 7)
				write_reg(cfm_pkg::REG_CHANNEL_MASKS, '0);
			else
				write_reg(cfm_pkg::REG_CHANNEL_MASKS, random_masks());
			case (p)
				0:       write_reg(cfm_pkg::REG_FILTER_LIMIT, limit_word(16'd0));
				1:       write_reg(cfm_pkg::REG_FILTER_LIMIT, '1);
				2:       write_reg(cfm_pkg::REG_FILTER_LIMIT, limit_word(16'd65530));
				default: write_reg(cfm_pkg::REG_FILTER_LIMIT,
					limit_word(16'($urandom_range(0, 60))));
			endcase
			case (p)
				3:       write_reg(cfm_pkg::REG_SETTLE_LIMIT, limit_word(16'hFFFF));
				4:       write_reg(cfm_pkg::REG_SETTLE_LIMIT, limit_word(16'd0));
				5:       write_reg(cfm_pkg::REG_SETTLE_LIMIT, limit_word(16'd65530));
				default: write_reg(cfm_pkg::REG_SETTLE_LIMIT,
					limit_word(16'($urandom_range(0, 80))));
			endcase
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});
			// Every fourth phase flips the run flag often, so settling rarely completes.
			run_div = (p % 4 == 3) ? 6 : 60;
			quiet   = (p % 5 == 2);
			if ($urandom_range(0, 1) == 0)
				stuck = '0;
			repeat (PHASE_TICKS) random_tick();
			drain();
		end

		// Settle limit at all ones: the timer can never exceed it, so checking never
		// starts in this phase.
		quiet   = 1'b1;
		cur_run = 1'b1;
		write_reg(cfm_pkg::REG_CHANNEL_MASKS, '1);
		write_reg(cfm_pkg::REG_FILTER_LIMIT, limit_word(16'd500));
		write_reg(cfm_pkg::REG_SETTLE_LIMIT, limit_word(16'hFFFF));
		stuck = '0;
		for (int i = 0; i < LIMIT_TICKS; i++)
			send_tick(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cur_run);
		drain();

		// Filter limit at all ones: every channel disagrees on every tick, so the timers
		// keep climbing without ever reaching the limit.
		write_reg(cfm_pkg::REG_SETTLE_LIMIT, limit_word(16'd0));
		write_reg(cfm_pkg::REG_FILTER_LIMIT, limit_word(16'hFFFF));
		for (int i = 0; i < LIMIT_TICKS; i++) begin
			lim_outs = 8'($urandom_range(0, 255));
			send_tick(lim_outs, ~healthy_feedback(lim_outs), cur_run);
		end
		quiet = 1'b0;
		repeat (20) random_tick();
		drain();

		// Give any stray result time to show.
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d predicted results never arrived", $time, sb.pending());
		$display("Sent %0d tick requests over %0d register writes; %0d results compared.",
			ticks_sent, writes_done, sb.compared);
		$display("Channels were checked on %0d ticks, %0d of them with a fault raised.",
			sb.checked_ticks, sb.fault_ticks);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
